/* hdl/vo_pkg.sv */
// Package with widths, constants and sideband types shared by the orthonormalization pipeline.
`default_nettype none
package vo_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int IN_FRAC_BITS = 28;
    localparam int OUT_FRAC     = DATA_WIDTH - 2;
    localparam int MAG_W        = DATA_WIDTH;
    localparam int THR_W        = 31;
    localparam int AXIS_W       = 2;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int ROOT_W       = SQ_W / 2;
    localparam int NUM_W        = MAG_W + OUT_FRAC;
    localparam int QUO_W        = OUT_FRAC + 1;
    localparam int PROD_W       = QUO_W + MAG_W;
    localparam int DMAG_W       = PROD_W - IN_FRAC_BITS;
    localparam int HALF_W       = 16;
    localparam int PART_W       = DMAG_W + HALF_W;
    localparam int PM_SHIFT     = IN_FRAC_BITS - HALF_W;
    localparam int PM_W         = PART_W + 1 - PM_SHIFT;
    localparam int RES_W        = PM_W + 2;
    localparam int RM_W         = PM_W;
    localparam int RS_W         = OUT_FRAC + 1;
    localparam int SH_MAX       = RM_W - RS_W;
    localparam int SH_W         = $clog2(SH_MAX + 1);
    localparam int SHN_W        = ROOT_W + SH_MAX;

    localparam int IN_TDATA_W   = ((6 * DATA_WIDTH + AXIS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = 3 * DATA_WIDTH;
    localparam int OUT_TUSER_W  = 2;

    localparam logic [QUO_W-1:0] UNIT_ONE = QUO_W'(1) << OUT_FRAC;

    localparam logic [AXIS_W-1:0] AXIS_X     = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y     = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z     = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_SPARE = 2'd3;

    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [AXIS_W-1:0] axis_t;

    typedef struct packed {
        logic [2:0]     sn;
        mag_t [2:0]     sm;
        logic [2:0]     fn;
        mag_t [2:0]     fm;
        axis_t          axis1;
        axis_t          axis2;
    } vo_sq1_side_t;

    typedef struct packed {
        logic [2:0]     sn;
        logic [2:0]     fn;
        mag_t [2:0]     fm;
        axis_t          axis1;
        axis_t          axis2;
        logic           fb1;
    } vo_div1_side_t;

    typedef struct packed {
        logic [2:0]                rn;
        logic [2:0][RS_W-1:0]      rs;
        logic [SH_W-1:0]           sh;
        axis_t                     axis2;
        logic                      fb1;
    } vo_sq2_side_t;

    typedef struct packed {
        logic [2:0]     rn;
        axis_t          axis2;
        logic           fb1;
        logic           fb2;
    } vo_div2_side_t;

endpackage
`default_nettype wire

/* hdl/vo_isqrt.sv */
// Pipelined floor square root, one result bit per stage, with a sideband that travels alongside.
`default_nettype none
module vo_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      ce,
    input  logic                      in_valid,
    input  logic [vo_pkg::SQ_W-1:0]   in_value,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [vo_pkg::ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0]         out_side
);
    import vo_pkg::*;

    localparam int STEPS = ROOT_W;

    logic [STEPS-1:0]  valid_reg;
    logic [SQ_W-1:0]   rem_reg  [STEPS];
    logic [SQ_W-1:0]   root_reg [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            logic              valid_in;
            logic [SQ_W-1:0]   rem_in;
            logic [SQ_W-1:0]   root_in;
            logic [SIDE_W-1:0] side_in;
            logic [SQ_W-1:0]   trial;
            logic [SQ_W-1:0]   rem_next;
            logic [SQ_W-1:0]   root_next;

            if (k == 0)
            begin : g_first
                assign valid_in = in_valid;
                assign rem_in   = in_value;
                assign root_in  = '0;
                assign side_in  = in_side;
            end
            else
            begin : g_rest
                assign valid_in = valid_reg[k-1];
                assign rem_in   = rem_reg[k-1];
                assign root_in  = root_reg[k-1];
                assign side_in  = side_reg[k-1];
            end

            always_comb
            begin
                trial = root_in + BIT_VAL;
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = (root_in >> 1) + BIT_VAL;
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (ce)
                begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

/* hdl/vo_div.sv */
// Three-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
`default_nettype none
module vo_div #(
    parameter int SIDE_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ce,
    input  logic                                in_valid,
    input  logic [2:0][vo_pkg::NUM_W-1:0]       in_num,
    input  logic [vo_pkg::ROOT_W-1:0]           in_den,
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_valid,
    output logic [2:0][vo_pkg::QUO_W-1:0]       out_quo,
    output logic [SIDE_W-1:0]                   out_side
);
    import vo_pkg::*;

    localparam int STEPS = QUO_W;

    logic [STEPS-1:0]             valid_reg;
    logic [2:0][NUM_W-1:0]        rem_reg  [STEPS];
    logic [2:0][QUO_W-1:0]        quo_reg  [STEPS];
    logic [ROOT_W-1:0]            den_reg  [STEPS];
    logic [SIDE_W-1:0]            side_reg [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            localparam int QBIT = STEPS - 1 - k;
            logic                  valid_in;
            logic [2:0][NUM_W-1:0] rem_in;
            logic [2:0][QUO_W-1:0] quo_in;
            logic [ROOT_W-1:0]     den_in;
            logic [SIDE_W-1:0]     side_in;
            logic [NUM_W-1:0]      den_sh;
            logic [2:0][NUM_W-1:0] rem_next;
            logic [2:0][QUO_W-1:0] quo_next;

            if (k == 0)
            begin : g_first
                assign valid_in = in_valid;
                assign rem_in   = in_num;
                assign quo_in   = '0;
                assign den_in   = in_den;
                assign side_in  = in_side;
            end
            else
            begin : g_rest
                assign valid_in = valid_reg[k-1];
                assign rem_in   = rem_reg[k-1];
                assign quo_in   = quo_reg[k-1];
                assign den_in   = den_reg[k-1];
                assign side_in  = side_reg[k-1];
            end

            always_comb
            begin
                den_sh   = NUM_W'(den_in) << QBIT;
                rem_next = rem_in;
                quo_next = quo_in;
                for (int l = 0; l < 3; l++)
                begin
                    if (rem_in[l] >= den_sh)
                    begin
                        rem_next[l]       = rem_in[l] - den_sh;
                        quo_next[l][QBIT] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (ce)
                begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k]  <= rem_next;
                    quo_reg[k]  <= quo_next;
                    den_reg[k]  <= den_in;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STEPS-1];
    assign out_quo   = quo_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

/* hdl/vo_proj.sv */
// Projection removal: dot product, projection, residual, range shift and sum of squares.
`default_nettype none
module vo_proj (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [2:0][vo_pkg::QUO_W-1:0] in_quo,
    input  vo_pkg::vo_div1_side_t         in_side,
    output logic                          out_valid,
    output logic [vo_pkg::SQ_W-1:0]       out_sum,
    output vo_pkg::vo_sq2_side_t          out_side
);
    import vo_pkg::*;

    localparam int STAGES = 11;
    localparam logic [PROD_W-1:0]   RND_DOT = PROD_W'(1) << (IN_FRAC_BITS - 1);
    localparam logic [PART_W:0]     RND_PM  = (PART_W + 1)'(1) << (PM_SHIFT - 1);

    typedef struct packed {
        logic [2:0][QUO_W-1:0] qm;
        logic [2:0]            qn;
        logic [2:0]            fn;
        mag_t [2:0]            fm;
        axis_t                 axis2;
        logic                  fb1;
    } carry_t;

    logic [STAGES-1:0] vld_reg;

    // Stage E: fallback selection and dot product terms.
    carry_t                 e_carry_next, e_carry_reg;
    logic [2:0][PROD_W-1:0] e_prod_next, e_prod_reg;
    // Stage F: signed partial sums.
    carry_t                 f_carry_reg;
    logic [PROD_W-1:0]      f_pos_next, f_pos_reg, f_neg_next, f_neg_reg;
    // Stage G: magnitude of the dot product.
    carry_t                 g_carry_reg;
    logic                   g_dneg_next, g_dneg_reg;
    logic [PROD_W-1:0]      g_raw_next, g_raw_reg;
    // Stage H: rounding to Q.30.
    carry_t                 h_carry_reg;
    logic                   h_dneg_reg;
    logic [DMAG_W-1:0]      h_dmag_next, h_dmag_reg;
    // Stage I: split projection products.
    carry_t                 i_carry_reg;
    logic [2:0]             i_pneg_next, i_pneg_reg;
    logic [2:0][PART_W-1:0] i_a_next, i_a_reg, i_b_next, i_b_reg;
    // Stage J: projection magnitude.
    carry_t                 j_carry_reg;
    logic [2:0]             j_pneg_reg;
    logic [2:0][PM_W-1:0]   j_pm_next, j_pm_reg;
    // Stage K: signed residual.
    carry_t                 k_carry_reg;
    logic [2:0][RES_W-1:0]  k_r_next, k_r_reg;
    // Stage L0: sign and magnitude of the residual.
    axis_t                  l0_axis2_reg, l1_axis2_reg, m_axis2_reg, n_axis2_reg;
    logic                   l0_fb1_reg, l1_fb1_reg, m_fb1_reg, n_fb1_reg;
    logic [2:0]             l0_rn_next, l0_rn_reg, l1_rn_reg, m_rn_reg, n_rn_reg;
    logic [2:0][RM_W-1:0]   l0_rm_next, l0_rm_reg;
    // Stage L1: shift into square-safe range.
    logic [SH_W-1:0]        l1_sh_next, l1_sh_reg, m_sh_reg, n_sh_reg;
    logic [2:0][RS_W-1:0]   l1_rs_next, l1_rs_reg, m_rs_reg, n_rs_reg;
    // Stage M: squares. Stage N: sum.
    logic [2:0][SQ_W-1:0]   m_sq_next, m_sq_reg;
    logic [SQ_W-1:0]        n_sum_next, n_sum_reg;

    always_comb
    begin
        logic [QUO_W-1:0]       qm;
        logic                   qn;
        logic signed [RES_W-1:0] qv;
        logic signed [RES_W-1:0] pv;
        logic [RES_W-1:0]       rabs;
        logic [RM_W-1:0]        ror;

        // Stage E
        e_carry_next.fn    = in_side.fn;
        e_carry_next.fm    = in_side.fm;
        e_carry_next.axis2 = in_side.axis2;
        e_carry_next.fb1   = in_side.fb1;
        for (int i = 0; i < 3; i++)
        begin
            if (in_side.fb1)
            begin
                qm = (AXIS_W'(i) == in_side.axis1) ? UNIT_ONE : '0;
                qn = 1'b0;
            end
            else
            begin
                qm = in_quo[i];
                qn = in_side.sn[i];
            end
            e_carry_next.qm[i] = qm;
            e_carry_next.qn[i] = qn;
            e_prod_next[i]     = PROD_W'(qm) * PROD_W'(in_side.fm[i]);
        end

        // Stage F
        f_pos_next = '0;
        f_neg_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (e_carry_reg.qn[i] != e_carry_reg.fn[i])
            begin
                f_neg_next = f_neg_next + e_prod_reg[i];
            end
            else
            begin
                f_pos_next = f_pos_next + e_prod_reg[i];
            end
        end

        // Stage G
        g_dneg_next = f_neg_reg > f_pos_reg;
        g_raw_next  = g_dneg_next ? (f_neg_reg - f_pos_reg) : (f_pos_reg - f_neg_reg);

        // Stage H
        h_dmag_next = DMAG_W'((g_raw_reg + RND_DOT) >> IN_FRAC_BITS);

        // Stage I: the low half of each fiber magnitude enters as a truncated product.
        for (int i = 0; i < 3; i++)
        begin
            i_pneg_next[i] = h_dneg_reg ^ h_carry_reg.fn[i];
            i_a_next[i]    = PART_W'(h_dmag_reg) * PART_W'(h_carry_reg.fm[i][MAG_W-1:HALF_W]);
            i_b_next[i]    = PART_W'(h_dmag_reg) * PART_W'(h_carry_reg.fm[i][HALF_W-1:0]);
        end

        // Stage J
        for (int i = 0; i < 3; i++)
        begin
            j_pm_next[i] = PM_W'(((PART_W + 1)'(i_a_reg[i]) + RND_PM
                                  + (PART_W + 1)'(i_b_reg[i] >> HALF_W)) >> PM_SHIFT);
        end

        // Stage K
        for (int i = 0; i < 3; i++)
        begin
            qv = $signed(RES_W'(j_carry_reg.qm[i]));
            pv = $signed(RES_W'(j_pm_reg[i]));
            if (j_carry_reg.qn[i])
            begin
                qv = -qv;
            end
            if (j_pneg_reg[i])
            begin
                pv = -pv;
            end
            k_r_next[i] = qv - pv;
        end

        // Stage L0
        for (int i = 0; i < 3; i++)
        begin
            l0_rn_next[i] = k_r_reg[i][RES_W-1];
            rabs          = l0_rn_next[i] ? (-k_r_reg[i]) : k_r_reg[i];
            l0_rm_next[i] = rabs[RM_W-1:0];
        end

        // Stage L1: the leading bit of the OR equals that of the largest magnitude.
        ror        = l0_rm_reg[0] | l0_rm_reg[1] | l0_rm_reg[2];
        l1_sh_next = '0;
        for (int s = 1; s <= SH_MAX; s++)
        begin
            if (ror[RS_W - 1 + s])
            begin
                l1_sh_next = SH_W'(s);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            l1_rs_next[i] = RS_W'(l0_rm_reg[i] >> l1_sh_next);
        end

        // Stage M
        for (int i = 0; i < 3; i++)
        begin
            m_sq_next[i] = SQ_W'(l1_rs_reg[i]) * SQ_W'(l1_rs_reg[i]);
        end

        // Stage N
        n_sum_next = m_sq_reg[0] + m_sq_reg[1] + m_sq_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            e_carry_reg  <= e_carry_next;
            e_prod_reg   <= e_prod_next;
            f_carry_reg  <= e_carry_reg;
            f_pos_reg    <= f_pos_next;
            f_neg_reg    <= f_neg_next;
            g_carry_reg  <= f_carry_reg;
            g_dneg_reg   <= g_dneg_next;
            g_raw_reg    <= g_raw_next;
            h_carry_reg  <= g_carry_reg;
            h_dneg_reg   <= g_dneg_reg;
            h_dmag_reg   <= h_dmag_next;
            i_carry_reg  <= h_carry_reg;
            i_pneg_reg   <= i_pneg_next;
            i_a_reg      <= i_a_next;
            i_b_reg      <= i_b_next;
            j_carry_reg  <= i_carry_reg;
            j_pneg_reg   <= i_pneg_reg;
            j_pm_reg     <= j_pm_next;
            k_carry_reg  <= j_carry_reg;
            k_r_reg      <= k_r_next;
            l0_axis2_reg <= k_carry_reg.axis2;
            l0_fb1_reg   <= k_carry_reg.fb1;
            l0_rn_reg    <= l0_rn_next;
            l0_rm_reg    <= l0_rm_next;
            l1_axis2_reg <= l0_axis2_reg;
            l1_fb1_reg   <= l0_fb1_reg;
            l1_rn_reg    <= l0_rn_reg;
            l1_sh_reg    <= l1_sh_next;
            l1_rs_reg    <= l1_rs_next;
            m_axis2_reg  <= l1_axis2_reg;
            m_fb1_reg    <= l1_fb1_reg;
            m_rn_reg     <= l1_rn_reg;
            m_sh_reg     <= l1_sh_reg;
            m_rs_reg     <= l1_rs_reg;
            m_sq_reg     <= m_sq_next;
            n_axis2_reg  <= m_axis2_reg;
            n_fb1_reg    <= m_fb1_reg;
            n_rn_reg     <= m_rn_reg;
            n_sh_reg     <= m_sh_reg;
            n_rs_reg     <= m_rs_reg;
            n_sum_reg    <= n_sum_next;
        end
    end

    assign out_valid      = vld_reg[STAGES-1];
    assign out_sum        = n_sum_reg;
    assign out_side.rn    = n_rn_reg;
    assign out_side.rs    = n_rs_reg;
    assign out_side.sh    = n_sh_reg;
    assign out_side.axis2 = n_axis2_reg;
    assign out_side.fb1   = n_fb1_reg;

endmodule
`default_nettype wire

/* hdl/vector3_orthonormalize.sv */
// Top level of the 3-D sheet vector orthonormalization pipeline.
// Throughput: one beat per cycle while the output buffer is not full; the stages are the
// two 32-step square root pipelines and the two 31-step divider pipelines, each retiring
// one bit per cycle.
// A two-entry output buffer lets the pipeline take one more beat while a result waits.
// Reset: rst_n clears all valid bits and sets norm_threshold to 1; payload is not reset.
`default_nettype none
module vector3_orthonormalize (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration: norm_threshold, unsigned Q3.28.
    input  logic                               cfg_we,
    input  logic [vo_pkg::THR_W-1:0]           cfg_wdata,
    // Input beats.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // From bit 0: sheet_x, sheet_y, sheet_z, fiber_x, fiber_y, fiber_z, fallback_axis, zero pad.
    input  logic [vo_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Output beats.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // From bit 0: unit_x, unit_y, unit_z.
    output logic [vo_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // From bit 0: first_fallback, second_fallback.
    output logic [vo_pkg::OUT_TUSER_W-1:0]     m_tuser
);
    import vo_pkg::*;

    localparam int SQ1_SIDE_W  = $bits(vo_sq1_side_t);
    localparam int DIV1_SIDE_W = $bits(vo_div1_side_t);
    localparam int SQ2_SIDE_W  = $bits(vo_sq2_side_t);
    localparam int DIV2_SIDE_W = $bits(vo_div2_side_t);
    localparam int AXIS_LSB    = 6 * DATA_WIDTH;
    localparam logic [DATA_WIDTH-1:0] OUT_ONE = DATA_WIDTH'(UNIT_ONE);

    logic                 ce;
    logic [THR_W-1:0]     thr_reg;

    // Output register plus one skid entry. While the skid entry is full the pipeline halts.
    logic                   out_valid_reg, skid_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, skid_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg, skid_user_reg;

    // The whole pipeline advances together; it halts only when the output buffer is full.
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(1);
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // Stage A: split each component into sign and magnitude, and resolve both axes.
    logic         a_valid_reg;
    vo_sq1_side_t a_side_next, a_side_reg;

    always_comb
    begin
        logic [DATA_WIDTH-1:0] sv;
        logic [DATA_WIDTH-1:0] fv;
        axis_t                 raw;
        for (int i = 0; i < 3; i++)
        begin
            sv                = s_tdata[i * DATA_WIDTH +: DATA_WIDTH];
            fv                = s_tdata[(i + 3) * DATA_WIDTH +: DATA_WIDTH];
            a_side_next.sn[i] = sv[DATA_WIDTH-1];
            a_side_next.fn[i] = fv[DATA_WIDTH-1];
            a_side_next.sm[i] = sv[DATA_WIDTH-1] ? (~sv + 1'b1) : sv;
            a_side_next.fm[i] = fv[DATA_WIDTH-1] ? (~fv + 1'b1) : fv;
        end
        raw = s_tdata[AXIS_LSB +: AXIS_W];
        unique case (raw) inside
            AXIS_X, AXIS_SPARE:
            begin
                a_side_next.axis1 = AXIS_X;
                a_side_next.axis2 = AXIS_Y;
            end
            AXIS_Y:
            begin
                a_side_next.axis1 = AXIS_Y;
                a_side_next.axis2 = AXIS_Z;
            end
            AXIS_Z:
            begin
                a_side_next.axis1 = AXIS_Z;
                a_side_next.axis2 = AXIS_X;
            end
            default:
            begin
                a_side_next.axis1 = AXIS_X;
                a_side_next.axis2 = AXIS_Y;
            end
        endcase
    end

    // Stage B: squares. Stage C: sum of squares.
    logic                 b_valid_reg, c_valid_reg;
    vo_sq1_side_t         b_side_reg, c_side_reg;
    logic [2:0][SQ_W-1:0] b_sq_next, b_sq_reg;
    logic [SQ_W-1:0]      c_sum_next, c_sum_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_sq_next[i] = SQ_W'(a_side_reg.sm[i]) * SQ_W'(a_side_reg.sm[i]);
        end
        c_sum_next = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
    end

    // First norm.
    logic                  r1_valid;
    logic [ROOT_W-1:0]     r1_root;
    logic [SQ1_SIDE_W-1:0] r1_side_vec;
    vo_sq1_side_t          r1_side;

    vo_isqrt #(
        .SIDE_W (SQ1_SIDE_W)
    ) u_sqrt1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (c_valid_reg),
        .in_value  (c_sum_reg),
        .in_side   (c_side_reg),
        .out_valid (r1_valid),
        .out_root  (r1_root),
        .out_side  (r1_side_vec)
    );

    assign r1_side = vo_sq1_side_t'(r1_side_vec);

    // Stage D: threshold test and rounded dividends for the first unit vector.
    logic                  d_valid_reg;
    vo_div1_side_t         d_side_next, d_side_reg;
    logic [2:0][NUM_W-1:0] d_num_next, d_num_reg;
    logic [ROOT_W-1:0]     d_den_reg;

    always_comb
    begin
        d_side_next.sn    = r1_side.sn;
        d_side_next.fn    = r1_side.fn;
        d_side_next.fm    = r1_side.fm;
        d_side_next.axis1 = r1_side.axis1;
        d_side_next.axis2 = r1_side.axis2;
        d_side_next.fb1   = (r1_root == '0) || (r1_root < ROOT_W'(thr_reg));
        for (int i = 0; i < 3; i++)
        begin
            d_num_next[i] = (NUM_W'(r1_side.sm[i]) << OUT_FRAC) + NUM_W'(r1_root >> 1);
        end
    end

    logic                   q1_valid;
    logic [2:0][QUO_W-1:0]  q1_quo;
    logic [DIV1_SIDE_W-1:0] q1_side_vec;

    vo_div #(
        .SIDE_W (DIV1_SIDE_W)
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (d_valid_reg),
        .in_num    (d_num_reg),
        .in_den    (d_den_reg),
        .in_side   (d_side_reg),
        .out_valid (q1_valid),
        .out_quo   (q1_quo),
        .out_side  (q1_side_vec)
    );

    // Projection removal and second sum of squares.
    logic            p_valid;
    logic [SQ_W-1:0] p_sum;
    vo_sq2_side_t    p_side;

    vo_proj u_proj (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (q1_valid),
        .in_quo    (q1_quo),
        .in_side   (vo_div1_side_t'(q1_side_vec)),
        .out_valid (p_valid),
        .out_sum   (p_sum),
        .out_side  (p_side)
    );

    // Second norm.
    logic                  r2_valid;
    logic [ROOT_W-1:0]     r2_root;
    logic [SQ2_SIDE_W-1:0] r2_side_vec;
    vo_sq2_side_t          r2_side;

    vo_isqrt #(
        .SIDE_W (SQ2_SIDE_W)
    ) u_sqrt2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (p_valid),
        .in_value  (p_sum),
        .in_side   (p_side),
        .out_valid (r2_valid),
        .out_root  (r2_root),
        .out_side  (r2_side_vec)
    );

    assign r2_side = vo_sq2_side_t'(r2_side_vec);

    // Stage O: the second norm is compared in Q.30 after undoing the range shift.
    logic                  o_valid_reg;
    vo_div2_side_t         o_side_next, o_side_reg;
    logic [2:0][NUM_W-1:0] o_num_next, o_num_reg;
    logic [ROOT_W-1:0]     o_den_reg;

    always_comb
    begin
        o_side_next.rn    = r2_side.rn;
        o_side_next.axis2 = r2_side.axis2;
        o_side_next.fb1   = r2_side.fb1;
        o_side_next.fb2   = (r2_root == '0)
                            || ((SHN_W'(r2_root) << r2_side.sh)
                                < (SHN_W'(thr_reg) << (OUT_FRAC - IN_FRAC_BITS)));
        for (int i = 0; i < 3; i++)
        begin
            o_num_next[i] = (NUM_W'(r2_side.rs[i]) << OUT_FRAC) + NUM_W'(r2_root >> 1);
        end
    end

    logic                   q2_valid;
    logic [2:0][QUO_W-1:0]  q2_quo;
    logic [DIV2_SIDE_W-1:0] q2_side_vec;
    vo_div2_side_t          q2_side;

    vo_div #(
        .SIDE_W (DIV2_SIDE_W)
    ) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (o_valid_reg),
        .in_num    (o_num_reg),
        .in_den    (o_den_reg),
        .in_side   (o_side_reg),
        .out_valid (q2_valid),
        .out_quo   (q2_quo),
        .out_side  (q2_side_vec)
    );

    assign q2_side = vo_div2_side_t'(q2_side_vec);

    // Stage P: final axis fallback and signed output words.
    logic                   fin_valid_reg;
    logic [OUT_TDATA_W-1:0] fin_data_next, fin_data_reg;
    logic [OUT_TUSER_W-1:0] fin_user_next, fin_user_reg;

    always_comb
    begin
        logic [QUO_W-1:0]      m;
        logic                  ng;
        logic [DATA_WIDTH-1:0] w;
        for (int i = 0; i < 3; i++)
        begin
            if (q2_side.fb2)
            begin
                m  = (AXIS_W'(i) == q2_side.axis2) ? UNIT_ONE : '0;
                ng = 1'b0;
            end
            else
            begin
                m  = q2_quo[i];
                ng = q2_side.rn[i];
            end
            w = DATA_WIDTH'(m);
            fin_data_next[i * DATA_WIDTH +: DATA_WIDTH] = ng ? (~w + 1'b1) : w;
        end
        fin_user_next = {q2_side.fb2, q2_side.fb1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            o_valid_reg   <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_valid_reg   <= s_tvalid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= r1_valid;
            o_valid_reg   <= r2_valid;
            fin_valid_reg <= q2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_side_reg   <= a_side_next;
            b_side_reg   <= a_side_reg;
            b_sq_reg     <= b_sq_next;
            c_side_reg   <= b_side_reg;
            c_sum_reg    <= c_sum_next;
            d_side_reg   <= d_side_next;
            d_num_reg    <= d_num_next;
            d_den_reg    <= r1_root;
            o_side_reg   <= o_side_next;
            o_num_reg    <= o_num_next;
            o_den_reg    <= r2_root;
            fin_data_reg <= fin_data_next;
            fin_user_reg <= fin_user_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (fin_valid_reg)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (fin_valid_reg)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_data_reg <= fin_data_reg;
                skid_user_reg <= fin_user_reg;
            end
            else
            begin
                out_data_reg <= fin_data_reg;
                out_user_reg <= fin_user_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // The skid entry is only ever filled behind a waiting output beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat while the output register is empty");

    // A held skid entry keeps its contents until the output side takes a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid entry changed while the output was stalled");

    // A second fallback always yields exactly one unit axis component.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_user_reg[1]) |->
        ($countones({out_data_reg[DATA_WIDTH-1:0] == OUT_ONE,
                     out_data_reg[2*DATA_WIDTH-1:DATA_WIDTH] == OUT_ONE,
                     out_data_reg[3*DATA_WIDTH-1:2*DATA_WIDTH] == OUT_ONE}) == 1))
        else $error("second fallback result is not a single unit axis");

endmodule
`default_nettype wire

/* tb/vector3_orthonormalize_tb.sv */
// Testbench for the vector3_orthonormalize pipeline: directed beats and random stream traffic against a predictor.
`default_nettype none
module vector3_orthonormalize_tb;
    import vo_pkg::*;

    typedef longint unsigned u64_t;

    // One input beat as the testbench sees it.
    typedef struct {
        logic signed [31:0] sx, sy, sz;
        logic signed [31:0] fx, fy, fz;
        axis_t              axis;
    } sheet_beat_t;

    // One output beat: the unit vector and both fallback flags.
    typedef struct {
        logic [31:0] ux, uy, uz;
        logic        fb1, fb2;
    } unit_beat_t;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 200;
    localparam int PHASE_ITEMS = 160;

    // Scoreboard: predicts the orthonormalized vector of each accepted beat and checks
    // output beats against those predictions in arrival order.
    class unit_vector_scoreboard;
        logic [THR_W-1:0] threshold;
        unit_beat_t       expected_units[$];
        int               mismatches;

        function new();
            threshold   = 1;
            mismatches  = 0;
        endfunction

        static function void split_mag(input logic [31:0] v, output bit ng, output u64_t mg);
            ng = v[31];
            mg = ng ? (64'd0 - u64_t'({{32{v[31]}}, v})) : u64_t'(v);
        endfunction

        static function u64_t floor_sqrt(input u64_t v);
            u64_t r;
            u64_t b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // Magnitude scaled to Q1.30 of a unit vector, rounded half up.
        static function u64_t scale_unit(input u64_t m, input u64_t n);
            return ((m << OUT_FRAC) + (n >> 1)) / n;
        endfunction

        function void predict_unit(input sheet_beat_t b);
            bit         sn[3], fn[3], qn[3], rn[3];
            u64_t       sm[3], fm[3], qm[3], rm[3];
            u64_t       sum, n1, n2, pos, neg, dmag, big, a, lo, pm, m;
            longint     qv, pv, r;
            bit         dneg, fb1, fb2, ng;
            int         ax1, ax2, sh;
            logic [31:0] s_in[3], f_in[3];
            unit_beat_t e;
            s_in = '{b.sx, b.sy, b.sz};
            f_in = '{b.fx, b.fy, b.fz};
            // The spare axis code behaves like x.
            ax1 = (b.axis == AXIS_SPARE) ? int'(AXIS_X) : int'(b.axis);
            ax2 = (ax1 + 1) % 3;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                split_mag(s_in[i], sn[i], sm[i]);
                split_mag(f_in[i], fn[i], fm[i]);
                sum += sm[i] * sm[i];
            end
            n1  = floor_sqrt(sum);
            fb1 = (n1 == 0) || (n1 < u64_t'(threshold));
            for (int i = 0; i < 3; i++)
            begin
                if (fb1)
                begin
                    qn[i] = 0;
                    qm[i] = (i == ax1) ? (64'd1 << OUT_FRAC) : 0;
                end
                else
                begin
                    qn[i] = sn[i];
                    qm[i] = scale_unit(sm[i], n1);
                end
            end
            // Dot product with the fiber, kept as separate positive and negative sums.
            pos = 0;
            neg = 0;
            for (int i = 0; i < 3; i++)
                if (qn[i] != fn[i])
                    neg += qm[i] * fm[i];
                else
                    pos += qm[i] * fm[i];
            dneg = neg > pos;
            dmag = dneg ? (neg - pos) : (pos - neg);
            dmag = (dmag + (64'd1 << (IN_FRAC_BITS - 1))) >> IN_FRAC_BITS;
            big = 0;
            for (int i = 0; i < 3; i++)
            begin
                // The low half of the fiber magnitude enters through a truncated product.
                a  = dmag * (fm[i] >> 16);
                lo = dmag * (fm[i] & 64'hFFFF);
                pm = (a + (64'd1 << (IN_FRAC_BITS - 17)) + (lo >> 16)) >> (IN_FRAC_BITS - 16);
                qv = qn[i] ? -longint'(qm[i]) : longint'(qm[i]);
                pv = (dneg != fn[i]) ? -longint'(pm) : longint'(pm);
                r  = qv - pv;
                rn[i] = r < 0;
                rm[i] = rn[i] ? u64_t'(-r) : u64_t'(r);
                if (rm[i] > big)
                    big = rm[i];
            end
            sh = 0;
            while ((big >> sh) >= (64'd1 << 31))
                sh++;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                rm[i] >>= sh;
                sum += rm[i] * rm[i];
            end
            n2  = floor_sqrt(sum);
            fb2 = (n2 == 0) ||
                  ((n2 << sh) < (u64_t'(threshold) << (OUT_FRAC - IN_FRAC_BITS)));
            for (int i = 0; i < 3; i++)
            begin
                if (fb2)
                begin
                    ng = 0;
                    m  = (i == ax2) ? (64'd1 << OUT_FRAC) : 0;
                end
                else
                begin
                    ng = rn[i];
                    m  = scale_unit(rm[i], n2);
                end
                m = ng ? (64'd0 - m) : m;
                if (i == 0)
                    e.ux = m[31:0];
                else if (i == 1)
                    e.uy = m[31:0];
                else
                    e.uz = m[31:0];
            end
            e.fb1 = fb1;
            e.fb2 = fb2;
            expected_units.push_back(e);
        endfunction

        function void compare_unit(input unit_beat_t got);
            unit_beat_t e;
            if (expected_units.size() == 0)
            begin
                $display("%0t: output beat with nothing expected: %h %h %h fb %b%b",
                         $time, got.ux, got.uy, got.uz, got.fb1, got.fb2);
                mismatches++;
                return;
            end
            e = expected_units.pop_front();
            if (got.ux !== e.ux)
            begin
                $display("%0t: unit_x expected %h actual %h", $time, e.ux, got.ux);
                mismatches++;
            end
            if (got.uy !== e.uy)
            begin
                $display("%0t: unit_y expected %h actual %h", $time, e.uy, got.uy);
                mismatches++;
            end
            if (got.uz !== e.uz)
            begin
                $display("%0t: unit_z expected %h actual %h", $time, e.uz, got.uz);
                mismatches++;
            end
            if (got.fb1 !== e.fb1)
            begin
                $display("%0t: first_fallback expected %b actual %b", $time, e.fb1, got.fb1);
                mismatches++;
            end
            if (got.fb2 !== e.fb2)
            begin
                $display("%0t: second_fallback expected %b actual %b", $time, e.fb2, got.fb2);
                mismatches++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [THR_W-1:0]         cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    // From bit 0: sheet_x, sheet_y, sheet_z, fiber_x, fiber_y, fiber_z, fallback_axis, zero pad.
    logic [IN_TDATA_W-1:0]    s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    // From bit 0: unit_x, unit_y, unit_z.
    logic [OUT_TDATA_W-1:0]   m_tdata;
    // From bit 0: first_fallback, second_fallback.
    logic [OUT_TUSER_W-1:0]   m_tuser;

    unit_vector_scoreboard    sb;
    sheet_beat_t              cur_beat;
    bit                       no_gaps;
    int                       idle_cycles;

    vector3_orthonormalize dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Both handshakes are observed at the rising edge, where inputs have been stable
    // since the falling edge.
    always @(posedge clk)
    begin
        unit_beat_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.predict_unit(cur_beat);
            if (m_tvalid && m_tready)
            begin
                got.ux  = m_tdata[31:0];
                got.uy  = m_tdata[63:32];
                got.uz  = m_tdata[95:64];
                got.fb1 = m_tuser[0];
                got.fb2 = m_tuser[1];
                sb.compare_unit(got);
            end
            // Watchdog: any beat on either side counts as progress.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Output side: each result draws its own stall before tready rises.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Drives one beat after a random gap and holds it until it is taken.
    task automatic send_sheet(input sheet_beat_t b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        cur_beat <= b;
        s_tdata  <= {6'd0, b.axis, b.fz, b.fy, b.fx, b.sz, b.sy, b.sx};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_units.size() != 0)
            @(negedge clk);
    endtask

    // The register is only written with the pipeline empty.
    task automatic write_threshold(input logic [THR_W-1:0] v);
        wait_drained();
        repeat (150)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.threshold = v;
    endtask

    function automatic sheet_beat_t mk(input logic [31:0] sx, sy, sz, fx, fy, fz,
                                       input axis_t ax);
        sheet_beat_t b;
        b.sx = sx; b.sy = sy; b.sz = sz;
        b.fx = fx; b.fy = fy; b.fz = fz;
        b.axis = ax;
        return b;
    endfunction

    function automatic logic [31:0] span(input int unsigned half);
        return $urandom_range(0, 2 * half) - half;
    endfunction

    function automatic sheet_beat_t random_sheet();
        sheet_beat_t b;
        int unsigned k;
        b.axis = axis_t'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                b = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, b.axis);
            end
            3, 4, 5:
            begin
                // Fiber components at most one in magnitude, sheet components at most four.
                b = mk(span(1 << 30), span(1 << 30), span(1 << 30),
                       span(1 << 28), span(1 << 28), span(1 << 28), b.axis);
            end
            6:
            begin
                // Sheet nearly parallel to the fiber: the remainder collapses.
                b.fx = span(1 << 28);
                b.fy = span(1 << 28);
                b.fz = span(1 << 28);
                k    = $urandom_range(1, 3);
                b.sx = b.fx * k + span(3);
                b.sy = b.fy * k + span(3);
                b.sz = b.fz * k + span(3);
            end
            7:
            begin
                // Norms close to small thresholds.
                b = mk(span(64), span(64), span(64), span(1 << 28), span(1 << 28),
                       span(1 << 28), b.axis);
            end
            8:
            begin
                b = mk($urandom, span(1 << 29), span(1 << 16), 0, 0, 0, b.axis);
            end
            default:
            begin
                // Sheet and fiber on the same axis: unless the first step falls back, the second one does.
                k = $urandom_range(0, 2);
                b = mk(0, 0, 0, 0, 0, 0, b.axis);
                if (k == 0)
                begin
                    b.sx = span(1 << 31 - 1);
                    b.fx = 32'sd1 << 28;
                end
                else if (k == 1)
                begin
                    b.sy = span(1 << 31 - 1);
                    b.fy = 32'sd1 << 28;
                end
                else
                begin
                    b.sz = span(1 << 31 - 1);
                    b.fz = -(32'sd1 << 28);
                end
            end
        endcase
        return b;
    endfunction

    task automatic random_phase(input int count);
        int pause_at;
        pause_at = $urandom_range(0, count - 1);
        for (int i = 0; i < count; i++)
        begin
            // Some stretches run without any idling on either side.
            if (i % 40 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (i == pause_at)
                wait_drained();
            send_sheet(random_sheet());
        end
        no_gaps = 0;
    endtask

    initial
    begin
        logic [31:0] one;
        sb          = new();
        no_gaps     = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cur_beat    = mk(0, 0, 0, 0, 0, 0, AXIS_X);
        one         = 32'd1 << 28;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats under the reset threshold.
        send_sheet(mk(0, 0, 0, 0, 0, 0, AXIS_X));
        send_sheet(mk(0, 0, 0, 0, 0, 0, AXIS_Y));
        send_sheet(mk(0, 0, 0, 0, 0, 0, AXIS_Z));
        send_sheet(mk(0, 0, 0, 0, 0, 0, AXIS_SPARE));
        send_sheet(mk(32'h7FFFFFFF, 0, 0, 0, 0, 0, AXIS_X));
        send_sheet(mk(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000, AXIS_Y));
        send_sheet(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, AXIS_Z));
        send_sheet(mk(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
                      32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF, AXIS_SPARE));
        send_sheet(mk(1, 0, 0, 0, 0, 0, AXIS_Y));
        send_sheet(mk(one, 0, 0, one, 0, 0, AXIS_X));
        send_sheet(mk(one, 0, 0, one, 0, 0, AXIS_Z));
        send_sheet(mk(0, 0, one, 0, 0, one, AXIS_Z));
        send_sheet(mk(0, 0, 0, 0, 0, one, AXIS_Z));
        send_sheet(mk(0, 0, 0, 0, 0, one, AXIS_SPARE));
        send_sheet(mk(one, one, 0, 0, 0, one, AXIS_Y));
        send_sheet(mk(1, 32'd1 << 30, 0, 0, 0, 0, AXIS_X));
        send_sheet(mk(-one, 0, 0, 0, one, 0, AXIS_Y));
        send_sheet(mk(-one, one, -one, one, -one, one, AXIS_Z));
        random_phase(PHASE_ITEMS);

        // Threshold extremes and a few ordinary settings in between.
        write_threshold('0);
        send_sheet(mk(0, 0, 0, 0, 0, 0, AXIS_Z));
        send_sheet(mk(1, 0, 0, 1, 0, 0, AXIS_Y));
        random_phase(PHASE_ITEMS);
        write_threshold(31'h7FFFFFFF);
        send_sheet(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, AXIS_X));
        random_phase(PHASE_ITEMS);
        write_threshold(31'(one));
        random_phase(PHASE_ITEMS);
        write_threshold(31'd1 << 20);
        random_phase(PHASE_ITEMS);
        write_threshold(31'($urandom_range(1, 200)));
        random_phase(PHASE_ITEMS / 2);
        write_threshold(31'd1);
        random_phase(PHASE_ITEMS / 2);

        wait_drained();
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_units.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* vector3_orthonormalize.f */
hdl/vo_pkg.sv
hdl/vo_isqrt.sv
hdl/vo_div.sv
hdl/vo_proj.sv
hdl/vector3_orthonormalize.sv
tb/vector3_orthonormalize_tb.sv
